// ===== src/dda_pkg.sv =====
// ---------------------------------------------------------------------------
// dda_pkg
// shared types and codes for the dda line point generator
// ---------------------------------------------------------------------------
package dda_pkg;

   // operation codes carried on req_tuser
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic load_start;
      logic load_step;
      logic div_step;
   } dda_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic len_zero;
      logic div_last;
   } dda_status_type;

endpackage

// ===== src/dda_ctrl.sv =====
// ---------------------------------------------------------------------------
// dda_ctrl
// handshake control and divider sequencing for the line generator
// ---------------------------------------------------------------------------
module dda_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_op,
   input  logic                    rsp_tready,
   input  dda_pkg::dda_status_type status,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   output dda_pkg::dda_cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DIV  = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic accept;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   assign cmd.load_start = accept && (req_op == dda_pkg::OP_START);
   assign cmd.load_step  = accept && (req_op == dda_pkg::OP_STEP);
   assign cmd.div_step   = (state_ff == ST_DIV);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load_start && !status.len_zero) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // a result is held until taken; a new beat reloads it
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/dda_dpath.sv =====
// ---------------------------------------------------------------------------
// dda_dpath
// position accumulators, step counter and radix-2 increment divider
// ---------------------------------------------------------------------------
module dda_dpath #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dda_pkg::dda_cmd_type    cmd,
   input  logic [COORD_BITS-1:0]   start_x,
   input  logic [COORD_BITS-1:0]   start_y,
   input  logic [COORD_BITS-1:0]   end_x,
   input  logic [COORD_BITS-1:0]   end_y,
   output dda_pkg::dda_status_type status,
   output logic [COORD_BITS-1:0]   point_x,
   output logic [COORD_BITS-1:0]   point_y,
   output logic                    last,
   output logic                    done_res
);

   localparam int C     = COORD_BITS;
   localparam int F     = FRAC_BITS;
   localparam int POS_W = C + 1 + F;
   localparam int INC_W = F + 2;
   localparam int Q_W   = F + 1;
   localparam int CNT_W = $clog2(F + 1);

   logic [POS_W-1:0] x_pos_ff, y_pos_ff;
   logic [POS_W-1:0] x_pos_in, y_pos_in;
   logic [INC_W-1:0] x_inc_ff, y_inc_ff;
   logic [INC_W-1:0] x_inc_in, y_inc_in;
   logic [C-1:0]     left_ff, left_in;
   logic [C-1:0]     left_dec;

   logic [C-1:0]     len_ff;
   logic [C:0]       x_rem_ff, y_rem_ff, x_rem_in, y_rem_in;
   logic [Q_W-1:0]   x_q_ff, y_q_ff, x_q_in, y_q_in;
   logic             x_neg_ff, y_neg_ff;
   logic [CNT_W-1:0] cnt_ff;

   logic [C-1:0]     pt_x_ff, pt_y_ff, pt_x_in, pt_y_in;
   logic             last_ff, last_in, done_ff, done_in;

   logic [C:0]       dx, dy;
   logic [C-1:0]     ax, ay, len;
   logic [C:0]       x_trial, y_trial;
   logic             x_ge, y_ge;
   logic [POS_W-1:0] x_pos_step, y_pos_step;

   // start decode: signed deltas, magnitudes, major axis span
   always_comb begin
      dx  = {1'b0, end_x} - {1'b0, start_x};
      dy  = {1'b0, end_y} - {1'b0, start_y};
      ax  = dx[C] ? C'(-dx) : dx[C-1:0];
      ay  = dy[C] ? C'(-dy) : dy[C-1:0];
      len = (ax > ay) ? ax : ay;
   end

   assign status.len_zero = (len == '0);
   assign status.div_last = (cnt_ff == CNT_W'(F));

   // one quotient bit a cycle, first bit is the integer (1.0) position
   always_comb begin
      x_trial  = (cnt_ff == '0) ? x_rem_ff : {x_rem_ff[C-1:0], 1'b0};
      y_trial  = (cnt_ff == '0) ? y_rem_ff : {y_rem_ff[C-1:0], 1'b0};
      x_ge     = (x_trial >= {1'b0, len_ff});
      y_ge     = (y_trial >= {1'b0, len_ff});
      x_rem_in = x_ge ? (x_trial - {1'b0, len_ff}) : x_trial;
      y_rem_in = y_ge ? (y_trial - {1'b0, len_ff}) : y_trial;
      x_q_in   = {x_q_ff[Q_W-2:0], x_ge};
      y_q_in   = {y_q_ff[Q_W-2:0], y_ge};
   end

   assign x_pos_step = x_pos_ff + {{(POS_W-INC_W){x_inc_ff[INC_W-1]}}, x_inc_ff};
   assign y_pos_step = y_pos_ff + {{(POS_W-INC_W){y_inc_ff[INC_W-1]}}, y_inc_ff};
   assign left_dec   = left_ff - 1'b1;

   always_comb begin
      x_pos_in = x_pos_ff;
      y_pos_in = y_pos_ff;
      x_inc_in = x_inc_ff;
      y_inc_in = y_inc_ff;
      left_in  = left_ff;
      pt_x_in  = pt_x_ff;
      pt_y_in  = pt_y_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      priority if (cmd.load_start) begin
         x_pos_in = {1'b0, start_x, 1'b1, {(F-1){1'b0}}};
         y_pos_in = {1'b0, start_y, 1'b1, {(F-1){1'b0}}};
         x_inc_in = '0;
         y_inc_in = '0;
         left_in  = len;
         pt_x_in  = start_x;
         pt_y_in  = start_y;
         last_in  = (len == '0);
         done_in  = 1'b0;
      end else if (cmd.load_step) begin
         if (left_ff == '0) begin
            // line already ended: repeat the final point
            pt_x_in = x_pos_ff[F+C-1:F];
            pt_y_in = y_pos_ff[F+C-1:F];
            last_in = 1'b1;
            done_in = 1'b1;
         end else begin
            x_pos_in = x_pos_step;
            y_pos_in = y_pos_step;
            left_in  = left_dec;
            pt_x_in  = x_pos_step[F+C-1:F];
            pt_y_in  = y_pos_step[F+C-1:F];
            last_in  = (left_dec == '0);
            done_in  = 1'b0;
         end
      end else if (cmd.div_step && status.div_last) begin
         x_inc_in = x_neg_ff ? INC_W'(-{1'b0, x_q_in}) : {1'b0, x_q_in};
         y_inc_in = y_neg_ff ? INC_W'(-{1'b0, y_q_in}) : {1'b0, y_q_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_pos_ff <= '0;
         y_pos_ff <= '0;
         x_inc_ff <= '0;
         y_inc_ff <= '0;
         left_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         x_pos_ff <= x_pos_in;
         y_pos_ff <= y_pos_in;
         x_inc_ff <= x_inc_in;
         y_inc_ff <= y_inc_in;
         left_ff  <= left_in;
         if (cmd.load_start) begin
            cnt_ff <= '0;
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   // divider payload and result beat, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.load_start) begin
         len_ff   <= len;
         x_rem_ff <= {1'b0, ax};
         y_rem_ff <= {1'b0, ay};
         x_q_ff   <= '0;
         y_q_ff   <= '0;
         x_neg_ff <= dx[C];
         y_neg_ff <= dy[C];
      end else if (cmd.div_step) begin
         x_rem_ff <= x_rem_in;
         y_rem_ff <= y_rem_in;
         x_q_ff   <= x_q_in;
         y_q_ff   <= y_q_in;
      end
      pt_x_ff <= pt_x_in;
      pt_y_ff <= pt_y_in;
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign point_x  = pt_x_ff;
   assign point_y  = pt_y_ff;
   assign last     = last_ff;
   assign done_res = done_ff;

endmodule

// ===== src/dda_line_point_generator.sv =====
// ---------------------------------------------------------------------------
// dda_line_point_generator
// digital differential analyzer line rasterizer, one point per beat
// ---------------------------------------------------------------------------
// usage:
//   req channel: tuser is the op (start a line / next point), tdata holds
//   start_x, start_y, end_x, end_y. every accepted beat yields exactly one
//   rsp beat carrying point_x, point_y in tdata, last on tlast and done on
//   tuser (a step that came after the final point)
//   latency: the rsp beat is valid the cycle after the req beat is taken
//   throughput: step beats stream at one point per cycle while rsp_tready
//   stays high. a start beat whose endpoints differ holds req_tready low
//   while the restoring divider forms both per-step increments one
//   quotient bit per cycle. a zero-length start does not run the divider
//   the first point of a line is emitted at once, before the division ends
//   reset: position, increments and the step count clear to zero, so a step
//   before any start returns (0,0) with last and done set
//   stall: the rsp register holds its beat while rsp_tready is low, and a
//   new req beat is taken in the same cycle the held beat drains
// ---------------------------------------------------------------------------
module dda_line_point_generator #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: start_x, start_y, end_x, end_y from the lowest bit up
   input  logic [((4*COORD_BITS+7)/8)*8-1:0] req_tdata,
   // req_tuser: op
   input  logic                  req_tuser,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // rsp_tdata: point_x, point_y from the lowest bit up, zero filled
   output logic [((2*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   // rsp_tuser: done_res
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready
);

   localparam int C          = COORD_BITS;
   localparam int RSP_DATA_W = ((2*COORD_BITS+7)/8)*8;

   dda_pkg::dda_cmd_type    cmd;
   dda_pkg::dda_status_type status;
   logic [C-1:0]            point_x, point_y;

   dda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .rsp_tready (rsp_tready),
      .status     (status),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   dda_dpath #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .start_x  (req_tdata[C-1:0]),
      .start_y  (req_tdata[2*C-1:C]),
      .end_x    (req_tdata[3*C-1:2*C]),
      .end_y    (req_tdata[4*C-1:3*C]),
      .status   (status),
      .point_x  (point_x),
      .point_y  (point_y),
      .last     (rsp_tlast),
      .done_res (rsp_tuser)
   );

   // pack points, upper pad bits read as zero
   assign rsp_tdata = RSP_DATA_W'({point_y, point_x});

endmodule

// ===== src/dda_checker.sv =====
// ---------------------------------------------------------------------------
// dda_checker
// port level checks for the dda line point generator
// ---------------------------------------------------------------------------
module dda_checker #(
   parameter int COORD_BITS = 12
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic [((4*COORD_BITS+7)/8)*8-1:0]     req_tdata,
   input logic                                  req_tuser,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic [((2*COORD_BITS+7)/8)*8-1:0]     rsp_tdata,
   input logic                                  rsp_tuser,
   input logic                                  rsp_tlast,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready
);

   localparam int C = COORD_BITS;

   logic req_beat;
   logic start_beat;
   logic same_ends;

   assign req_beat   = req_tvalid && req_tready;
   assign start_beat = req_beat && (req_tuser == dda_pkg::OP_START);
   assign same_ends  = (req_tdata[C-1:0] == req_tdata[3*C-1:2*C])
                    && (req_tdata[2*C-1:C] == req_tdata[4*C-1:3*C]);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   // every accepted beat shows a result in the next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> rsp_tvalid)
      else $error("no rsp beat after req beat");

   // done only ever comes on a final point
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("done without last");

   // zero-length line is a single final point
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      start_beat && same_ends |=> rsp_tlast && !rsp_tuser)
      else $error("zero-length line not closed on start");

   // a real line opens with a non-final point at the start endpoint
   a_line_open: assert property (@(posedge clock) disable iff (reset)
      start_beat && !same_ends |=> !rsp_tlast && !rsp_tuser
         && (rsp_tdata[C-1:0] == $past(req_tdata[C-1:0]))
         && (rsp_tdata[2*C-1:C] == $past(req_tdata[2*C-1:C])))
      else $error("line start point wrong");

endmodule

bind dda_line_point_generator dda_checker #(
   .COORD_BITS (COORD_BITS)
) u_dda_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

// ===== test/dda_line_checker.sv =====
// ---------------------------------------------------------------------------
// dda_line_checker
// watches both streams of the dda line generator, predicts every point and
// compares each rsp beat field by field with the oldest predicted point
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dda_line_checker #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // req_tdata: start_x, start_y, end_x, end_y from the lowest bit up
   input  logic [((4*COORD_BITS+7)/8)*8-1:0]       req_tdata,
   // req_tuser: op
   input  logic                                    req_tuser,
   input  logic                                    req_tvalid,
   input  logic                                    req_tready,
   // rsp_tdata: point_x, point_y from the lowest bit up
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]       rsp_tdata,
   // rsp_tuser: done_res
   input  logic                                    rsp_tuser,
   input  logic                                    rsp_tlast,
   input  logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output int                                      fail_count,
   output int                                      points_owed
);

   localparam longint POS_MASK   = (longint'(1) << (COORD_BITS + FRAC_BITS + 1)) - 1;
   localparam longint UNIT_STEP  = longint'(1) << FRAC_BITS;
   localparam longint HALF_PIXEL = longint'(1) << (FRAC_BITS - 1);

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  last;
      logic                  done;
   } line_point_type;

   // predicted line state, q.FRAC_BITS positions and signed increments
   longint x_pos = 0;
   longint y_pos = 0;
   longint x_step = 0;
   longint y_step = 0;
   longint steps_left = 0;
   bit     drawing = 1'b0;

   line_point_type points_due[$];

   function automatic line_point_type advance_line(input logic op,
                                                   input logic [4*COORD_BITS-1:0] ends);
      longint         sx, sy, ex, ey, dx, dy, span;
      line_point_type pt;
      pt.last = 1'b0;
      pt.done = 1'b0;
      if (op == dda_pkg::OP_START) begin
         sx = longint'(ends[COORD_BITS-1:0]);
         sy = longint'(ends[2*COORD_BITS-1:COORD_BITS]);
         ex = longint'(ends[3*COORD_BITS-1:2*COORD_BITS]);
         ey = longint'(ends[4*COORD_BITS-1:3*COORD_BITS]);
         dx = ex - sx;
         dy = ey - sy;
         span = (dx < 0) ? -dx : dx;
         if (((dy < 0) ? -dy : dy) > span) begin
            span = (dy < 0) ? -dy : dy;
         end
         // signed division truncates toward zero
         x_step = (span == 0) ? 0 : (dx * UNIT_STEP) / span;
         y_step = (span == 0) ? 0 : (dy * UNIT_STEP) / span;
         x_pos = ((sx << FRAC_BITS) + HALF_PIXEL) & POS_MASK;
         y_pos = ((sy << FRAC_BITS) + HALF_PIXEL) & POS_MASK;
         steps_left = span;
         drawing = (span != 0);
         pt.last = (span == 0);
      end else if (!drawing || steps_left == 0) begin
         // line over or never started: repeat the held point
         drawing = 1'b0;
         pt.last = 1'b1;
         pt.done = 1'b1;
      end else begin
         x_pos = (x_pos + x_step) & POS_MASK;
         y_pos = (y_pos + y_step) & POS_MASK;
         steps_left = steps_left - 1;
         if (steps_left == 0) begin
            drawing = 1'b0;
         end
         pt.last = (steps_left == 0);
      end
      pt.x = COORD_BITS'(x_pos >> FRAC_BITS);
      pt.y = COORD_BITS'(y_pos >> FRAC_BITS);
      return pt;
   endfunction

   always @(posedge clock) begin
      line_point_type want, got, next_pt;
      if (reset) begin
         points_due.delete();
         fail_count = 0;
         x_pos      = 0;
         y_pos      = 0;
         x_step     = 0;
         y_step     = 0;
         steps_left = 0;
         drawing    = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            next_pt    = advance_line(req_tuser, req_tdata[4*COORD_BITS-1:0]);
            points_due = {points_due, next_pt};
         end
         if (rsp_tvalid && rsp_tready) begin
            got.x    = rsp_tdata[COORD_BITS-1:0];
            got.y    = rsp_tdata[2*COORD_BITS-1:COORD_BITS];
            got.last = rsp_tlast;
            got.done = rsp_tuser;
            if (points_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected point beat, expected none, got x=%0d y=%0d %s",
                        $time, got.x, got.y,
                        $sformatf("last=%0b done=%0b", got.last, got.done));
            end else begin
               want = points_due.pop_front();
               if (got.x !== want.x || got.y !== want.y ||
                   got.last !== want.last || got.done !== want.done) begin
                  fail_count++;
                  $display("%0t: point mismatch, expected x=%0d y=%0d last=%0b done=%0b, %s",
                           $time, want.x, want.y, want.last, want.done,
                           $sformatf("got x=%0d y=%0d last=%0b done=%0b",
                                     got.x, got.y, got.last, got.done));
               end
            end
         end
      end
      points_owed <= points_due.size();
   end

endmodule

// ===== test/tb_dda_line_point_generator.sv =====
// ---------------------------------------------------------------------------
// tb_dda_line_point_generator
// drives lines and point steps into the dda generator under random idling
// on both streams; the checker beside the block predicts and compares
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dda_line_point_generator;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 16;
   localparam int REQ_W      = ((4*COORD_BITS+7)/8)*8;
   localparam int RSP_W      = ((2*COORD_BITS+7)/8)*8;
   localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
   // slowest run: ~1100 beats, start beats held up by the divider, rsp idling 67 of 100
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 40;
   localparam int HOLD_OFF    = 300;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             req_tuser  = dda_pkg::OP_START;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   logic             rsp_tlast;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;

   int fail_count;
   int points_owed;
   int send_idle_pct   = 0;
   int rsp_idle_pct    = 0;
   bit long_stall      = 1'b0;
   int beats_sent      = 0;
   int cycle_count     = 0;

   always #2 clock = ~clock;

   dda_line_point_generator #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   dda_line_checker #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .fail_count  (fail_count),
      .points_owed (points_owed)
   );

   // watchdog against a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: random backpressure, or one long hold-off counted down here
   initial begin
      int hold_left;
      bit stall_taken;
      hold_left   = 0;
      stall_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (long_stall && !stall_taken) begin
            hold_left   = HOLD_OFF;
            stall_taken = 1'b1;
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left = hold_left - 1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // offer one req beat, idling first at the current rate, and return once
   // it is taken; tready is sampled at the falling edge, when all inputs
   // have settled, so the handshake seen here matches the block's edge
   task automatic offer_beat(input logic op, input logic [COORD_BITS-1:0] sx,
                             input logic [COORD_BITS-1:0] sy,
                             input logic [COORD_BITS-1:0] ex,
                             input logic [COORD_BITS-1:0] ey);
      logic taken;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_W'({ey, ex, sy, sx});
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      beats_sent++;
   endtask

   // start a line, then request a number of points; step beats carry junk data
   task automatic draw_line(input int sx, input int sy, input int ex, input int ey,
                            input int steps);
      offer_beat(dda_pkg::OP_START, COORD_BITS'(sx), COORD_BITS'(sy),
                 COORD_BITS'(ex), COORD_BITS'(ey));
      for (int i = 0; i < steps; i++) begin
         offer_beat(dda_pkg::OP_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                    COORD_BITS'($urandom), COORD_BITS'($urandom));
      end
   endtask

   // endpoint a random distance away from a coordinate, kept on the grid
   function automatic int nudge(input int c, input int reach);
      int v;
      v = c + $urandom_range(2 * reach) - reach;
      return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
   endfunction

   initial begin
      int sx, sy, ex, ey, span, steps, pick, reach, target;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: step before any start returns the reset point
      offer_beat(dda_pkg::OP_STEP, '0, '0, '0, '0);
      // zero-length line at the origin, then a step past its end
      draw_line(0, 0, 0, 0, 1);
      // full diagonal, restarted mid-line
      draw_line(0, 0, COORD_MAX, COORD_MAX, 3);
      // opposite corners, x delta negative and y delta positive, restarted mid-line
      draw_line(COORD_MAX, 0, 0, COORD_MAX, 2);
      // short x-major line run to its end and beyond
      draw_line(10, 20, 13, 18, 5);
      // short line at the top edge, run past its end
      draw_line(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX, 3);
      // zero-length line at the far corner
      draw_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0);
      // steep y-major line going down-left, run to its last point
      draw_line(5, 9, 4, 5, 4);

      // random: mostly whole lines, some cut short, some stray steps
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 67 : 0;
         rsp_idle_pct  = (phase == 0) ? 67 : (phase == 1) ? 33 : 0;
         // long receiver stall while the sender keeps offering
         if (phase == 2) begin
            long_stall = 1'b1;
         end
         target = beats_sent + 330;
         while (beats_sent < target) begin
            pick = $urandom_range(99);
            sx = $urandom_range(COORD_MAX);
            sy = $urandom_range(COORD_MAX);
            if (pick < 8) begin
               offer_beat(dda_pkg::OP_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                          COORD_BITS'($urandom), COORD_BITS'($urandom));
            end else if (pick < 15) begin
               draw_line(sx, sy, sx, sy, $urandom_range(2));
            end else if (pick < 30) begin
               // far endpoints, dropped by a restart partway
               draw_line(sx, sy, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                         $urandom_range(30));
            end else begin
               reach = ($urandom_range(9) == 0) ? 200 : 12;
               ex = nudge(sx, reach);
               ey = nudge(sy, reach);
               span = (ex > sx) ? ex - sx : sx - ex;
               if (((ey > sy) ? ey - sy : sy - ey) > span) begin
                  span = (ey > sy) ? ey - sy : sy - ey;
               end
               steps = span + $urandom_range(2);
               if ($urandom_range(7) == 0 && span > 0) begin
                  steps = $urandom_range(span - 1);
               end
               draw_line(sx, sy, ex, ey, steps);
            end
         end
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (points_owed != 0);
      // a start's division may still be running after its first point
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0 && points_owed == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
